>>> rtl/core/tace_pkg.sv
// tace_pkg: shared widths, register indexes, codes and types for the touch
// averaging and calibration block. No dependencies; used by tace_lane and
// touch_average_calibrate_events.
`default_nettype none

package tace_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int CNT_BITS      = 8;
    localparam int SUM_BITS      = SAMPLE_BITS + CNT_BITS;
    localparam int CAL_BITS      = 12;
    localparam int PROD_BITS     = 2 * CAL_BITS;
    localparam int COORD_BITS    = 16;
    localparam int STEP_BITS     = $clog2(SUM_BITS);
    localparam int IN_DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 12;
    localparam int ORIENT_BITS   = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BURST_LENGTH  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAW_MIN_X     = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAW_MIN_Y     = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAW_MAX_X     = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAW_MAX_Y     = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIENTATION   = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 4'd7;

    // reset values of the configuration registers
    localparam logic [CNT_BITS-1:0]    RST_BURST_LENGTH  = 8'd1;
    localparam logic [CAL_BITS-1:0]    RST_RAW_MIN_X     = 12'd180;
    localparam logic [CAL_BITS-1:0]    RST_RAW_MIN_Y     = 12'd120;
    localparam logic [CAL_BITS-1:0]    RST_RAW_MAX_X     = 12'd1870;
    localparam logic [CAL_BITS-1:0]    RST_RAW_MAX_Y     = 12'd1900;
    localparam logic [CAL_BITS-1:0]    RST_SCREEN_WIDTH  = 12'd240;
    localparam logic [CAL_BITS-1:0]    RST_SCREEN_HEIGHT = 12'd320;

    localparam logic [ORIENT_BITS-1:0] ORIENT_PORTRAIT       = 2'd0;
    localparam logic [ORIENT_BITS-1:0] ORIENT_LANDSCAPE      = 2'd1;
    localparam logic [ORIENT_BITS-1:0] ORIENT_PORTRAIT_FLIP  = 2'd2;
    localparam logic [ORIENT_BITS-1:0] ORIENT_LANDSCAPE_FLIP = 2'd3;

    localparam logic EV_BEGIN = 1'b0;
    localparam logic EV_END   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_CLIP,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ACC,
        OP_CLR,
        OP_AVG,
        OP_CLIP,
        OP_MUL,
        OP_DIV
    } t_lane_op;

    typedef struct packed {
        t_lane_op op;
        logic     first;
    } t_lane_ctl;

endpackage

`default_nettype wire

>>> rtl/core/tace_lane.sv
// tace_lane: one axis of the touch datapath: burst accumulator, bit-serial
// average divider, clip, shift-add scale multiply and bit-serial scale divide.
// Depends on tace_pkg; sequenced by touch_average_calibrate_events.
`default_nettype none

module tace_lane
    import tace_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_lane_ctl              i_ctl,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [CNT_BITS-1:0]    i_div,
    input  wire logic [CAL_BITS-1:0]    i_lo,
    input  wire logic [CAL_BITS-1:0]    i_hi,
    input  wire logic [CAL_BITS-1:0]    i_size,
    output logic      [CAL_BITS-1:0]    o_result
);

    logic [SUM_BITS-1:0]  r_sum;
    logic [CAL_BITS-1:0]  r_rem;
    logic [PROD_BITS-1:0] r_prod;
    logic [CAL_BITS-1:0]  r_d;
    logic [CAL_BITS-1:0]  r_q;

    logic [CNT_BITS:0]    w_avg_t;
    logic                 w_avg_ge;
    logic [CNT_BITS:0]    w_avg_r;
    logic [SUM_BITS-1:0]  w_lo_ext;
    logic [SUM_BITS-1:0]  w_hi_ext;
    logic [SUM_BITS-1:0]  w_clip_lo;
    logic [SUM_BITS-1:0]  w_clip;
    logic [CAL_BITS-1:0]  w_d;
    logic [CAL_BITS-1:0]  w_rng;
    logic                 w_eq;
    logic                 w_inv;
    logic [PROD_BITS-1:0] w_prod_next;
    logic [CAL_BITS-1:0]  w_cur;
    logic [CAL_BITS:0]    w_div_t;
    logic                 w_div_ge;
    logic [CAL_BITS:0]    w_div_r;

    // average: one quotient bit per cycle, shifted back into the sum
    assign w_avg_t  = {r_rem[CNT_BITS-1:0], r_sum[SUM_BITS-1]};
    assign w_avg_ge = (w_avg_t >= {1'b0, i_div});
    assign w_avg_r  = w_avg_ge ? (w_avg_t - {1'b0, i_div}) : w_avg_t;

    assign w_lo_ext  = SUM_BITS'(i_lo);
    assign w_hi_ext  = SUM_BITS'(i_hi);
    assign w_clip_lo = (r_sum < w_lo_ext) ? w_lo_ext : r_sum;
    assign w_clip    = (w_clip_lo > w_hi_ext) ? w_hi_ext : w_clip_lo;
    assign w_d       = w_clip[CAL_BITS-1:0] - i_lo;

    assign w_rng = i_hi - i_lo;
    assign w_eq  = (i_hi == i_lo);
    assign w_inv = (i_hi < i_lo);

    assign w_prod_next = {r_prod[PROD_BITS-2:0], 1'b0}
                       + (r_d[CAL_BITS-1] ? PROD_BITS'(i_size) : '0);

    // upper half of the product is below the range, so the quotient fits
    assign w_cur    = i_ctl.first ? r_prod[PROD_BITS-1:CAL_BITS] : r_rem;
    assign w_div_t  = {w_cur, r_prod[CAL_BITS-1]};
    assign w_div_ge = (w_div_t >= {1'b0, w_rng});
    assign w_div_r  = w_div_ge ? (w_div_t - {1'b0, w_rng}) : w_div_t;

    // limits reversed: clipping pins at the maximum, giving the full size
    assign o_result = w_eq ? '0 : (w_inv ? i_size : r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            case (i_ctl.op)
                OP_ACC:  r_sum <= r_sum + SUM_BITS'(i_sample);
                OP_CLR:  r_sum <= '0;
                OP_AVG:  r_sum <= {r_sum[SUM_BITS-2:0], w_avg_ge};
                OP_CLIP: r_sum <= '0;
                default: r_sum <= r_sum;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_ACC: begin
                r_rem <= '0;
            end
            OP_AVG: begin
                r_rem <= {{(CAL_BITS-CNT_BITS){1'b0}}, w_avg_r[CNT_BITS-1:0]};
            end
            OP_CLIP: begin
                r_d    <= w_d;
                r_prod <= '0;
            end
            OP_MUL: begin
                r_prod <= w_prod_next;
                r_d    <= {r_d[CAL_BITS-2:0], 1'b0};
            end
            OP_DIV: begin
                r_rem  <= w_div_r[CAL_BITS-1:0];
                r_prod <= {r_prod[PROD_BITS-2:0], 1'b0};
                r_q    <= {r_q[CAL_BITS-2:0], w_div_ge};
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/touch_average_calibrate_events.sv
// touch_average_calibrate_events: top level with stream ports, configuration
// registers, sequencer and press event logic. Depends on tace_pkg and tace_lane.
`default_nettype none

// Takes one raw touch sample pair per transfer (pen-down flag in tuser) and
// sums a burst of burst_length samples per axis. A sample that does not end a
// burst leaves the block idle. A pen-up leaves it idle too, or passes through
// the emit state to queue a press-end result when the pen was pressed. The
// sample that ends a burst holds the input while the bit-serial datapath of
// each axis runs: the average divider, clip, the shift-add scale multiply and
// the scale divider, then orientation. A reading that loads a press-begin
// result also passes through the emit state. Both axes run side by side. A
// result sits in an output register, so the next sample is taken while it
// waits. A second result stays queued, and the input stalls, until the
// receiver takes the first. The configuration port is always ready; write it
// only while the block is idle.
module touch_average_calibrate_events
    import tace_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_tvalid,
    output logic                          o_s_tready,
    // [11:0] raw_x, [23:12] raw_y
    input  wire logic [IN_DATA_BITS-1:0]  i_s_tdata,
    // [0] pen_down
    input  wire logic                     i_s_tuser,
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    // [15:0] coord_x, [31:16] coord_y
    output logic      [OUT_DATA_BITS-1:0] o_m_tdata,
    // [0] event_kind
    output logic                          o_m_tuser,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    logic [CNT_BITS-1:0]    r_burst;
    logic [CAL_BITS-1:0]    r_min_x;
    logic [CAL_BITS-1:0]    r_min_y;
    logic [CAL_BITS-1:0]    r_max_x;
    logic [CAL_BITS-1:0]    r_max_y;
    logic [ORIENT_BITS-1:0] r_orient;
    logic [CAL_BITS-1:0]    r_screen_w;
    logic [CAL_BITS-1:0]    r_screen_h;

    t_state                 r_state;
    t_state                 n_state;
    logic [STEP_BITS-1:0]   r_cnt;
    logic [STEP_BITS-1:0]   n_cnt;
    logic [CNT_BITS-1:0]    r_samples;
    logic                   r_was_pressed;
    logic                   r_pend_kind;
    logic [COORD_BITS-1:0]  r_last_x;
    logic [COORD_BITS-1:0]  r_last_y;
    logic                   r_out_valid;
    logic                   r_out_kind;
    logic [COORD_BITS-1:0]  r_out_x;
    logic [COORD_BITS-1:0]  r_out_y;

    t_lane_ctl              w_ctl;
    logic                   w_in_xfer;
    logic                   w_pen;
    logic [CNT_BITS-1:0]    w_n;
    logic [CNT_BITS-1:0]    w_cnt_next;
    logic                   w_burst_done;
    logic                   w_out_free;
    logic                   w_out_load;
    logic [CAL_BITS-1:0]    w_lane_x;
    logic [CAL_BITS-1:0]    w_lane_y;
    logic                   w_mirror_x;
    logic                   w_swap;
    logic [COORD_BITS-1:0]  w_mx;
    logic [COORD_BITS-1:0]  w_my;
    logic [COORD_BITS-1:0]  w_fin_x;
    logic [COORD_BITS-1:0]  w_fin_y;

    assign o_s_tready   = (r_state == ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign w_in_xfer    = i_s_tvalid && o_s_tready;
    assign w_pen        = i_s_tuser;
    assign w_n          = (r_burst == '0) ? CNT_BITS'(1) : r_burst;
    assign w_cnt_next   = r_samples + CNT_BITS'(1);
    assign w_burst_done = (w_cnt_next >= w_n);
    assign w_out_free   = !r_out_valid || i_m_tready;
    assign w_out_load   = (r_state == ST_EMIT) && w_out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {r_out_y, r_out_x};

    tace_lane u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_div    (w_n),
        .i_lo     (r_min_x),
        .i_hi     (r_max_x),
        .i_size   (r_screen_w),
        .o_result (w_lane_x)
    );

    tace_lane u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_div    (w_n),
        .i_lo     (r_min_y),
        .i_hi     (r_max_y),
        .i_size   (r_screen_h),
        .o_result (w_lane_y)
    );

    // orientation: mirror one axis with 16-bit wrap, then maybe swap
    assign w_mirror_x = (r_orient == ORIENT_PORTRAIT_FLIP)
                     || (r_orient == ORIENT_LANDSCAPE_FLIP);
    assign w_swap     = (r_orient == ORIENT_LANDSCAPE)
                     || (r_orient == ORIENT_LANDSCAPE_FLIP);
    assign w_mx = w_mirror_x ? (COORD_BITS'(r_screen_w) - COORD_BITS'(w_lane_x))
                             : COORD_BITS'(w_lane_x);
    assign w_my = w_mirror_x ? COORD_BITS'(w_lane_y)
                             : (COORD_BITS'(r_screen_h) - COORD_BITS'(w_lane_y));
    assign w_fin_x = w_swap ? w_my : w_mx;
    assign w_fin_y = w_swap ? w_mx : w_my;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst    <= RST_BURST_LENGTH;
            r_min_x    <= RST_RAW_MIN_X;
            r_min_y    <= RST_RAW_MIN_Y;
            r_max_x    <= RST_RAW_MAX_X;
            r_max_y    <= RST_RAW_MAX_Y;
            r_orient   <= ORIENT_PORTRAIT;
            r_screen_w <= RST_SCREEN_WIDTH;
            r_screen_h <= RST_SCREEN_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BURST_LENGTH:  r_burst    <= i_cfg_data[CNT_BITS-1:0];
                CFG_RAW_MIN_X:     r_min_x    <= i_cfg_data[CAL_BITS-1:0];
                CFG_RAW_MIN_Y:     r_min_y    <= i_cfg_data[CAL_BITS-1:0];
                CFG_RAW_MAX_X:     r_max_x    <= i_cfg_data[CAL_BITS-1:0];
                CFG_RAW_MAX_Y:     r_max_y    <= i_cfg_data[CAL_BITS-1:0];
                CFG_ORIENTATION:   r_orient   <= i_cfg_data[ORIENT_BITS-1:0];
                CFG_SCREEN_WIDTH:  r_screen_w <= i_cfg_data[CAL_BITS-1:0];
                CFG_SCREEN_HEIGHT: r_screen_h <= i_cfg_data[CAL_BITS-1:0];
                default:           r_burst    <= r_burst;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        w_ctl.op    = OP_HOLD;
        w_ctl.first = (r_cnt == '0);
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (w_in_xfer) begin
                    if (!w_pen) begin
                        w_ctl.op = OP_CLR;
                        if (r_was_pressed) begin
                            n_state = ST_EMIT;
                        end
                    end else begin
                        w_ctl.op = OP_ACC;
                        if (w_burst_done) begin
                            n_state = ST_AVG;
                        end
                    end
                end
            end
            ST_AVG: begin
                w_ctl.op = OP_AVG;
                n_cnt    = r_cnt + STEP_BITS'(1);
                if (r_cnt == STEP_BITS'(SUM_BITS - 1)) begin
                    n_state = ST_CLIP;
                    n_cnt   = '0;
                end
            end
            ST_CLIP: begin
                w_ctl.op = OP_CLIP;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                w_ctl.op = OP_MUL;
                n_cnt    = r_cnt + STEP_BITS'(1);
                if (r_cnt == STEP_BITS'(CAL_BITS - 1)) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end
            end
            ST_DIV: begin
                w_ctl.op = OP_DIV;
                n_cnt    = r_cnt + STEP_BITS'(1);
                if (r_cnt == STEP_BITS'(CAL_BITS - 1)) begin
                    n_state = ST_FIN;
                    n_cnt   = '0;
                end
            end
            ST_FIN: begin
                n_state = r_was_pressed ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples     <= '0;
            r_was_pressed <= 1'b0;
            r_pend_kind   <= EV_BEGIN;
            r_last_x      <= '0;
            r_last_y      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                if (!w_pen) begin
                    r_samples     <= '0;
                    r_was_pressed <= 1'b0;
                    r_pend_kind   <= EV_END;
                end else begin
                    r_samples <= w_burst_done ? '0 : w_cnt_next;
                end
            end
            if (r_state == ST_FIN) begin
                r_last_x <= w_fin_x;
                r_last_y <= w_fin_y;
                if (!r_was_pressed) begin
                    r_was_pressed <= 1'b1;
                    r_pend_kind   <= EV_BEGIN;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // press-end carries the last coordinate, press-begin the one just stored
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_kind <= r_pend_kind;
            r_out_x    <= r_last_x;
            r_out_y    <= r_last_y;
        end
    end

`ifndef ASSERT_OFF
    a_begin_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_pend_kind == EV_BEGIN) |-> r_was_pressed)
        else $error("press-begin queued without press state");

    a_end_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_pend_kind == EV_END) |-> !r_was_pressed)
        else $error("press-end queued while still pressed");

    a_avg_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AVG) |-> (r_cnt < STEP_BITS'(SUM_BITS)))
        else $error("average step count out of range");

    a_div_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == STEP_BITS'(CAL_BITS - 1)) |=> (r_state == ST_FIN))
        else $error("scale divide did not finish in time");

    a_load_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> o_m_tvalid)
        else $error("queued result not presented");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_touch_average_calibrate_events.sv
// tb_touch_average_calibrate_events: self-checking bench for the touch averaging,
// calibration and press event block. Predicts press-begin / press-end events
// in the bench and compares every output transfer. Depends on tace_pkg and the RTL.
`default_nettype none

module tb_touch_average_calibrate_events;
    import tace_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int QUIET_CYCLES   = 64;     // outlasts one full reading
    localparam int DRAIN_LIMIT    = 50_000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int NUM_PHASES     = 6;
    localparam int PRESSURE_PHASE = 4;
    localparam int LONG_PHASE     = 5;
    localparam int PHASE_ITEMS    = 150;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 4'd9;

    typedef struct packed {
        logic                  kind;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
    } touch_event_t;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_REG} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_EVENT} check_mode_t;

    // register rows: raw_x holds the index, raw_y the value
    typedef struct packed {
        row_kind_t    kind;
        logic         pen;
        logic [11:0]  raw_x;
        logic [11:0]  raw_y;
        check_mode_t  chk;
        touch_event_t want;
    } plan_row_t;

    localparam touch_event_t NO_EVENT = '0;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_s_tvalid = 1'b0;
    logic                     o_s_tready;
    logic [IN_DATA_BITS-1:0]  i_s_tdata = '0;
    logic                     i_s_tuser = 1'b0;
    logic                     o_m_tvalid;
    logic                     i_m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] o_m_tdata;
    logic                     o_m_tuser;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    touch_average_calibrate_events DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // bench copy of the configuration registers
    logic [CNT_BITS-1:0]    cfg_burst  = RST_BURST_LENGTH;
    logic [CAL_BITS-1:0]    cfg_min_x  = RST_RAW_MIN_X;
    logic [CAL_BITS-1:0]    cfg_min_y  = RST_RAW_MIN_Y;
    logic [CAL_BITS-1:0]    cfg_max_x  = RST_RAW_MAX_X;
    logic [CAL_BITS-1:0]    cfg_max_y  = RST_RAW_MAX_Y;
    logic [ORIENT_BITS-1:0] cfg_orient = ORIENT_PORTRAIT;
    logic [CAL_BITS-1:0]    cfg_width  = RST_SCREEN_WIDTH;
    logic [CAL_BITS-1:0]    cfg_height = RST_SCREEN_HEIGHT;

    // bench copy of the burst and press state
    logic [SUM_BITS-1:0]   acc_x = '0;
    logic [SUM_BITS-1:0]   acc_y = '0;
    logic [CNT_BITS-1:0]   samples_in_burst = '0;
    logic                  pen_pressed = 1'b0;
    logic [COORD_BITS-1:0] last_x = '0;
    logic [COORD_BITS-1:0] last_y = '0;

    touch_event_t pending_events[$];

    int errors        = 0;
    int items_sent    = 0;
    int events_seen   = 0;
    int reg_writes    = 0;
    int send_gap_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;

    plan_row_t directed_plan[$] = '{
        '{ROW_SAMPLE, 1'b0, 12'd4095, 12'd4095, CHK_NONE,  NO_EVENT},
        '{ROW_SAMPLE, 1'b1, 12'd180,  12'd120,  CHK_EVENT, '{EV_BEGIN, 16'd0, 16'd320}},
        '{ROW_SAMPLE, 1'b1, 12'd4095, 12'd4095, CHK_NONE,  NO_EVENT},
        '{ROW_SAMPLE, 1'b0, 12'd0,    12'd0,    CHK_EVENT, '{EV_END, 16'd240, 16'd0}},
        '{ROW_SAMPLE, 1'b1, 12'd0,    12'd0,    CHK_EVENT, '{EV_BEGIN, 16'd0, 16'd320}},
        '{ROW_SAMPLE, 1'b1, 12'd1025, 12'd1010, CHK_NONE,  NO_EVENT},
        '{ROW_SAMPLE, 1'b0, 12'hABC,  12'h543,  CHK_EVENT, '{EV_END, 16'd120, 16'd160}},
        // burst length zero behaves as one
        '{ROW_REG,    1'b0, 12'(CFG_BURST_LENGTH), 12'd0, CHK_NONE, NO_EVENT},
        '{ROW_SAMPLE, 1'b1, 12'd2000, 12'd60,   CHK_EVENT, '{EV_BEGIN, 16'd240, 16'd320}},
        '{ROW_SAMPLE, 1'b0, 12'd0,    12'd4095, CHK_EVENT, '{EV_END, 16'd240, 16'd320}},
        // pen-up in the middle of a burst drops the partial sums
        '{ROW_REG,    1'b0, 12'(CFG_BURST_LENGTH), 12'd3, CHK_NONE, NO_EVENT},
        '{ROW_SAMPLE, 1'b1, 12'd100,  12'd200,  CHK_NONE,  NO_EVENT},
        '{ROW_SAMPLE, 1'b1, 12'd4095, 12'd4095, CHK_NONE,  NO_EVENT},
        '{ROW_SAMPLE, 1'b0, 12'd0,    12'd0,    CHK_NONE,  NO_EVENT},
        '{ROW_SAMPLE, 1'b1, 12'd300,  12'd400,  CHK_MODEL, NO_EVENT},
        '{ROW_SAMPLE, 1'b1, 12'd500,  12'd600,  CHK_MODEL, NO_EVENT},
        '{ROW_SAMPLE, 1'b1, 12'd700,  12'd800,  CHK_MODEL, NO_EVENT},
        '{ROW_SAMPLE, 1'b0, 12'd1,    12'd2,    CHK_MODEL, NO_EVENT},
        // equal x limits, inverted y limits, flipped portrait
        '{ROW_REG,    1'b0, 12'(CFG_BURST_LENGTH),  12'd1,    CHK_NONE, NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_RAW_MIN_X),     12'd1000, CHK_NONE, NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_RAW_MAX_X),     12'd1000, CHK_NONE, NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_RAW_MIN_Y),     12'd3000, CHK_NONE, NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_RAW_MAX_Y),     12'd200,  CHK_NONE, NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_ORIENTATION),   12'(ORIENT_PORTRAIT_FLIP), CHK_NONE,
          NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_SCREEN_WIDTH),  12'd4095, CHK_NONE, NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_SCREEN_HEIGHT), 12'd4095, CHK_NONE, NO_EVENT},
        '{ROW_SAMPLE, 1'b1, 12'd0,    12'd0,    CHK_EVENT, '{EV_BEGIN, 16'd4095, 16'd4095}},
        '{ROW_SAMPLE, 1'b0, 12'd0,    12'd0,    CHK_EVENT, '{EV_END, 16'd4095, 16'd4095}},
        // zero screen size, flipped landscape, write to an unmapped index
        '{ROW_REG,    1'b0, 12'(CFG_ORIENTATION),   12'(ORIENT_LANDSCAPE_FLIP), CHK_NONE,
          NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_SCREEN_WIDTH),  12'd0,    CHK_NONE, NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_SCREEN_HEIGHT), 12'd0,    CHK_NONE, NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_UNMAPPED),      12'hFFF,  CHK_NONE, NO_EVENT},
        '{ROW_SAMPLE, 1'b1, 12'd4095, 12'd4095, CHK_EVENT, '{EV_BEGIN, 16'd0, 16'd0}},
        '{ROW_SAMPLE, 1'b0, 12'd4095, 12'd4095, CHK_EVENT, '{EV_END, 16'd0, 16'd0}},
        // full raw range, landscape
        '{ROW_REG,    1'b0, 12'(CFG_ORIENTATION),   12'(ORIENT_LANDSCAPE), CHK_NONE,
          NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_RAW_MIN_X),     12'd0,    CHK_NONE, NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_RAW_MAX_X),     12'd4095, CHK_NONE, NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_RAW_MIN_Y),     12'd0,    CHK_NONE, NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_RAW_MAX_Y),     12'd4095, CHK_NONE, NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_SCREEN_WIDTH),  12'd4095, CHK_NONE, NO_EVENT},
        '{ROW_REG,    1'b0, 12'(CFG_SCREEN_HEIGHT), 12'd4095, CHK_NONE, NO_EVENT},
        '{ROW_SAMPLE, 1'b1, 12'd4095, 12'd0,    CHK_EVENT, '{EV_BEGIN, 16'd4095, 16'd4095}},
        '{ROW_SAMPLE, 1'b1, 12'd0,    12'd4095, CHK_NONE,  NO_EVENT},
        '{ROW_SAMPLE, 1'b0, 12'd0,    12'd0,    CHK_EVENT, '{EV_END, 16'd0, 16'd0}},
        '{ROW_SAMPLE, 1'b1, 12'd2048, 12'd1024, CHK_MODEL, NO_EVENT},
        '{ROW_SAMPLE, 1'b0, 12'd0,    12'd0,    CHK_MODEL, NO_EVENT}
    };

    function automatic logic [COORD_BITS-1:0] scale_axis(
        input logic [SUM_BITS-1:0] v,
        input logic [CAL_BITS-1:0] lo,
        input logic [CAL_BITS-1:0] hi,
        input logic [CAL_BITS-1:0] size
    );
        longint c;
        longint l;
        longint h;
        longint r;
        c = longint'(v);
        l = longint'(lo);
        h = longint'(hi);
        if (c < l) c = l;
        if (c > h) c = h;
        if (h == l) return '0;
        r = (c - l) * longint'(size) / (h - l);
        return r[COORD_BITS-1:0];
    endfunction

    // advances the bench state by one sample; returns 1 when an event is due
    function automatic bit predict_touch(
        input  logic                   pen,
        input  logic [SAMPLE_BITS-1:0] raw_x,
        input  logic [SAMPLE_BITS-1:0] raw_y,
        output touch_event_t           ev
    );
        logic [SUM_BITS-1:0]   divisor;
        logic [SUM_BITS-1:0]   avg_x;
        logic [SUM_BITS-1:0]   avg_y;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic [COORD_BITS-1:0] tmp;
        ev = NO_EVENT;
        divisor = (cfg_burst == '0) ? SUM_BITS'(1) : SUM_BITS'(cfg_burst);
        if (!pen) begin
            acc_x = '0;
            acc_y = '0;
            samples_in_burst = '0;
            if (pen_pressed) begin
                pen_pressed = 1'b0;
                ev = '{EV_END, last_x, last_y};
                return 1'b1;
            end
            return 1'b0;
        end
        acc_x = acc_x + SUM_BITS'(raw_x);
        acc_y = acc_y + SUM_BITS'(raw_y);
        samples_in_burst = samples_in_burst + 1'b1;
        if (SUM_BITS'(samples_in_burst) < divisor) return 1'b0;

        avg_x = acc_x / divisor;
        avg_y = acc_y / divisor;
        acc_x = '0;
        acc_y = '0;
        samples_in_burst = '0;

        px = scale_axis(avg_x, cfg_min_x, cfg_max_x, cfg_width);
        py = scale_axis(avg_y, cfg_min_y, cfg_max_y, cfg_height);
        if (cfg_orient == ORIENT_PORTRAIT_FLIP || cfg_orient == ORIENT_LANDSCAPE_FLIP) begin
            px = COORD_BITS'(cfg_width) - px;
        end else begin
            py = COORD_BITS'(cfg_height) - py;
        end
        if (cfg_orient == ORIENT_LANDSCAPE || cfg_orient == ORIENT_LANDSCAPE_FLIP) begin
            tmp = px;
            px = py;
            py = tmp;
        end
        last_x = px;
        last_y = py;
        if (!pen_pressed) begin
            pen_pressed = 1'b1;
            ev = '{EV_BEGIN, px, py};
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left--;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : event_check
        touch_event_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected event: event_kind=%0d coord_x=%0d coord_y=%0d",
                       o_m_tuser, o_m_tdata[15:0], o_m_tdata[31:16]);
                errors++;
            end else begin
                want = pending_events.pop_front();
                events_seen++;
                if (o_m_tuser !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, o_m_tuser);
                    errors++;
                end
                if (o_m_tdata[15:0] !== want.cx) begin
                    $error("coord_x: expected %0d, got %0d", want.cx, o_m_tdata[15:0]);
                    errors++;
                end
                if (o_m_tdata[31:16] !== want.cy) begin
                    $error("coord_y: expected %0d, got %0d", want.cy, o_m_tdata[31:16]);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(
        input logic                   pen,
        input logic [SAMPLE_BITS-1:0] raw_x,
        input logic [SAMPLE_BITS-1:0] raw_y,
        input check_mode_t            chk,
        input touch_event_t           want
    );
        touch_event_t ev;
        bit           has_event;
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {raw_y, raw_x};
        i_s_tuser  <= pen;
        do @(posedge i_clk); while (!o_s_tready);
        has_event = predict_touch(pen, raw_x, raw_y, ev);
        case (chk)
            CHK_MODEL: if (has_event) pending_events.push_back(ev);
            CHK_EVENT: pending_events.push_back(want);
            default: ;
        endcase
        items_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BURST_LENGTH:  cfg_burst  = val[CNT_BITS-1:0];
            CFG_RAW_MIN_X:     cfg_min_x  = val;
            CFG_RAW_MIN_Y:     cfg_min_y  = val;
            CFG_RAW_MAX_X:     cfg_max_x  = val;
            CFG_RAW_MAX_Y:     cfg_max_y  = val;
            CFG_ORIENTATION:   cfg_orient = val[ORIENT_BITS-1:0];
            CFG_SCREEN_WIDTH:  cfg_width  = val;
            CFG_SCREEN_HEIGHT: cfg_height = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic wait_drain();
        i_s_tvalid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
    endtask

    // a reading that ends in no event may still be in flight after the drain
    task automatic wait_quiet();
        wait_drain();
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_raw(input logic [CAL_BITS-1:0] lo,
                                                        input logic [CAL_BITS-1:0] hi);
        int v;
        case ($urandom_range(3))
            0: v = int'(lo) + int'($urandom_range(8)) - 4;
            1: v = int'(hi) + int'($urandom_range(8)) - 4;
            default: v = int'($urandom_range(4095));
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return SAMPLE_BITS'(v);
    endfunction

    // one or more complete readings with the pen held, then usually a release
    task automatic send_press(input int release_pct);
        int n;
        int k;
        n = (cfg_burst == '0) ? 1 : int'(cfg_burst);
        k = (n > 8) ? 1 : int'($urandom_range(1, 3));
        repeat (k * n) begin
            send_item(1'b1, pick_raw(cfg_min_x, cfg_max_x), pick_raw(cfg_min_y, cfg_max_y),
                      CHK_MODEL, NO_EVENT);
        end
        if ($urandom_range(99) < release_pct) begin
            send_item(1'b0, SAMPLE_BITS'($urandom_range(4095)),
                      SAMPLE_BITS'($urandom_range(4095)), CHK_MODEL, NO_EVENT);
        end
    endtask

    task automatic random_limits(output logic [CAL_BITS-1:0] lo,
                                 output logic [CAL_BITS-1:0] hi);
        int a;
        case ($urandom_range(9))
            0: begin
                lo = CAL_BITS'($urandom_range(4095));
                hi = lo;
            end
            1: begin
                lo = CAL_BITS'($urandom_range(2048, 4095));
                hi = CAL_BITS'($urandom_range(0, 2047));
            end
            2: begin
                lo = '0;
                hi = '1;
            end
            default: begin
                a = int'($urandom_range(3000));
                lo = CAL_BITS'(a);
                hi = CAL_BITS'($urandom_range(a + 1, 4095));
            end
        endcase
    endtask

    task automatic setup_phase(input int phase);
        logic [CNT_BITS-1:0]    burst;
        logic [CAL_BITS-1:0]    lo_x;
        logic [CAL_BITS-1:0]    hi_x;
        logic [CAL_BITS-1:0]    lo_y;
        logic [CAL_BITS-1:0]    hi_y;
        logic [CAL_BITS-1:0]    width;
        logic [CAL_BITS-1:0]    height;
        logic [ORIENT_BITS-1:0] orient;
        wait_quiet();
        orient = ORIENT_BITS'($urandom_range(3));
        width  = ($urandom_range(3) == 0) ? '1 : CAL_BITS'($urandom_range(1, 4095));
        height = ($urandom_range(3) == 0) ? '1 : CAL_BITS'($urandom_range(1, 4095));
        if (phase == 0) begin
            burst = 8'd1;
            lo_x = '0;
            hi_x = '1;
            lo_y = '0;
            hi_y = '1;
            width = '1;
            height = '1;
            orient = ORIENT_PORTRAIT;
        end else if (phase == LONG_PHASE) begin
            burst = '1;
            lo_x = '0;
            hi_x = '1;
            lo_y = '0;
            hi_y = '1;
        end else begin
            case ($urandom_range(5))
                0: burst = 8'd0;
                1: burst = 8'd1;
                2: burst = 8'd2;
                3: burst = 8'd3;
                4: burst = 8'd4;
                default: burst = 8'd7;
            endcase
            random_limits(lo_x, hi_x);
            random_limits(lo_y, hi_y);
        end
        // unused upper data bits carry noise, the block must drop them
        cfg_write(CFG_BURST_LENGTH,  {4'($urandom_range(15)), burst});
        cfg_write(CFG_RAW_MIN_X,     lo_x);
        cfg_write(CFG_RAW_MIN_Y,     lo_y);
        cfg_write(CFG_RAW_MAX_X,     hi_x);
        cfg_write(CFG_RAW_MAX_Y,     hi_y);
        cfg_write(CFG_ORIENTATION,   {10'($urandom_range(1023)), orient});
        cfg_write(CFG_SCREEN_WIDTH,  width);
        cfg_write(CFG_SCREEN_HEIGHT, height);
    endtask

    task automatic run_traffic(input int target);
        int first;
        int n;
        int r;
        first = items_sent;
        while (items_sent - first < target) begin
            n = (cfg_burst == '0) ? 1 : int'(cfg_burst);
            r = int'($urandom_range(99));
            if (r < 75) begin
                send_press(85);
            end else if (r < 90) begin
                // burst cut short by a pen-up
                repeat ($urandom_range(n - 1)) begin
                    send_item(1'b1, SAMPLE_BITS'($urandom_range(4095)),
                              SAMPLE_BITS'($urandom_range(4095)), CHK_MODEL, NO_EVENT);
                end
                send_item(1'b0, SAMPLE_BITS'($urandom_range(4095)),
                          SAMPLE_BITS'($urandom_range(4095)), CHK_MODEL, NO_EVENT);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(1'($urandom_range(1)), SAMPLE_BITS'($urandom_range(4095)),
                              SAMPLE_BITS'($urandom_range(4095)), CHK_MODEL, NO_EVENT);
                end
            end
        end
    endtask

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int gap_pct[NUM_PHASES]   = '{0, 69, 0, 32, 0, 32};
        int stall_pct[NUM_PHASES] = '{0, 0, 69, 32, 0, 32};
        bit quiet;
        int waited;
        quiet = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_REG) begin
                if (!quiet) begin
                    wait_quiet();
                    quiet = 1'b1;
                end
                cfg_write(directed_plan[i].raw_x[CFG_IDX_BITS-1:0], directed_plan[i].raw_y);
            end else begin
                quiet = 1'b0;
                send_item(directed_plan[i].pen, directed_plan[i].raw_x, directed_plan[i].raw_y,
                          directed_plan[i].chk, directed_plan[i].want);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            setup_phase(phase);
            send_gap_pct   = gap_pct[phase];
            recv_stall_pct = stall_pct[phase];
            if (phase == PRESSURE_PHASE) begin
                // receiver holds off while full presses keep coming, then the
                // sender waits for every event before going on
                hold_request = HOLD_CYCLES;
                repeat (3) send_press(100);
                wait_drain();
                send_gap_pct   = 32;
                recv_stall_pct = 32;
                run_traffic(PHASE_ITEMS - 40);
            end else if (phase == LONG_PHASE) begin
                send_press(100);
                repeat (20) begin
                    send_item(1'b1, SAMPLE_BITS'($urandom_range(4095)),
                              SAMPLE_BITS'($urandom_range(4095)), CHK_MODEL, NO_EVENT);
                end
                send_item(1'b0, '0, '0, CHK_MODEL, NO_EVENT);
            end else begin
                run_traffic(PHASE_ITEMS);
            end
        end

        i_s_tvalid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        waited = 0;
        while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (pending_events.size() != 0) begin
            $error("%0d expected events never arrived", pending_events.size());
            errors++;
        end

        $display("sent %0d touch samples over %0d setups (%0d register writes)",
                 items_sent, NUM_PHASES + 1, reg_writes);
        $display("checked %0d press events, %0d mismatches", events_seen, errors);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/core/tace_pkg.sv
rtl/core/tace_lane.sv
rtl/core/touch_average_calibrate_events.sv
tb/sv/tb_touch_average_calibrate_events.sv
